// ----- sv/qfc_pkg.sv -----
// shared types and constants of the packet field codec
`timescale 1ns / 1ps
`default_nettype none
package qfc_pkg;

    // command carried in the slave-side tuser
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // field format codes
    localparam logic [3:0] FMT_VAR_AUTO = 4'd0;
    localparam logic [3:0] FMT_VAR_1    = 4'd1;
    localparam logic [3:0] FMT_VAR_2    = 4'd2;
    localparam logic [3:0] FMT_VAR_4    = 4'd3;
    localparam logic [3:0] FMT_FIX_1    = 4'd4;
    localparam logic [3:0] FMT_FIX_2    = 4'd5;
    localparam logic [3:0] FMT_FIX_3    = 4'd6;
    localparam logic [3:0] FMT_FIX_4    = 4'd7;
    localparam logic [3:0] FMT_FIX_8    = 4'd8;

    // largest value for each varint length
    localparam logic [63:0] VMAX1 = 64'h0000_0000_0000_003F;
    localparam logic [63:0] VMAX2 = 64'h0000_0000_0000_3FFF;
    localparam logic [63:0] VMAX4 = 64'h0000_0000_3FFF_FFFF;
    localparam logic [63:0] VMAX8 = 64'h3FFF_FFFF_FFFF_FFFF;

    // position reported on any error
    localparam logic [15:0] POS_ERROR = 16'hFFFF;

    // varint length prefixes (top two bits of the first byte)
    localparam logic [1:0] PFX_1 = 2'b00;
    localparam logic [1:0] PFX_2 = 2'b01;
    localparam logic [1:0] PFX_4 = 2'b10;
    localparam logic [1:0] PFX_8 = 2'b11;

    // depth of the job queue between front and back
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERRUN  = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_BADFMT   = 2'd3
    } t_qfc_status;

    // one job: either a run of encoded bytes or a single result
    typedef struct packed {
        logic        is_enc;
        logic [1:0]  prefix;
        logic [3:0]  len;
        logic [63:0] data;
        logic [15:0] npos;
        t_qfc_status status;
    } t_qfc_entry;

    // queue status seen by the top level
    typedef struct packed {
        logic full;
        logic empty;
    } t_qfc_qstat;

endpackage
`default_nettype wire

// ----- sv/qfc_front.sv -----
// front part: accepts items, classifies them and tracks the decode field
`timescale 1ns / 1ps
`default_nettype none
module qfc_front
    import qfc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic        i_command,
    input  wire logic [3:0]  i_format,
    input  wire logic [63:0] i_value,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [15:0] i_position,
    input  wire logic [15:0] i_buffer_length,
    output t_qfc_entry       o_entry,
    output logic             o_push
);

    logic        r_busy, n_busy;
    logic [3:0]  r_remain, n_remain;
    logic [63:0] r_acc, n_acc;
    logic [15:0] r_fend, n_fend;

    logic        enc_bad, enc_ovf;
    logic [3:0]  enc_len;
    logic [1:0]  enc_pfx;
    logic        dec_bad;
    logic [3:0]  dec_len;
    logic [63:0] dec_first;
    logic [3:0]  field_len;
    logic [16:0] field_end;
    logic        overrun;
    logic [63:0] acc_shift;
    logic [3:0]  remain_dec;
    t_qfc_entry  err_entry;

    // encode length, prefix and error classification
    always_comb begin
        enc_bad = 1'b0;
        enc_ovf = 1'b0;
        enc_len = 4'd1;
        enc_pfx = PFX_1;
        unique case (i_format)
            FMT_VAR_AUTO: begin
                if (i_value <= VMAX1) begin
                    enc_len = 4'd1;
                    enc_pfx = PFX_1;
                end else if (i_value <= VMAX2) begin
                    enc_len = 4'd2;
                    enc_pfx = PFX_2;
                end else if (i_value <= VMAX4) begin
                    enc_len = 4'd4;
                    enc_pfx = PFX_4;
                end else begin
                    enc_len = 4'd8;
                    enc_pfx = PFX_8;
                    enc_ovf = (i_value > VMAX8);
                end
            end
            FMT_VAR_1: begin
                enc_len = 4'd1;
                enc_pfx = PFX_1;
                enc_ovf = (i_value > VMAX1);
            end
            FMT_VAR_2: begin
                enc_len = 4'd2;
                enc_pfx = PFX_2;
                enc_ovf = (i_value > VMAX2);
            end
            FMT_VAR_4: begin
                enc_len = 4'd4;
                enc_pfx = PFX_4;
                enc_ovf = (i_value > VMAX4);
            end
            FMT_FIX_1: enc_len = 4'd1;
            FMT_FIX_2: enc_len = 4'd2;
            FMT_FIX_3: enc_len = 4'd3;
            FMT_FIX_4: enc_len = 4'd4;
            FMT_FIX_8: enc_len = 4'd8;
            default:   enc_bad = 1'b1;
        endcase
    end

    // decode first-byte length and payload bits
    always_comb begin
        dec_bad   = 1'b0;
        dec_len   = 4'd1;
        dec_first = {56'd0, i_data_byte};
        unique case (i_format)
            FMT_VAR_AUTO, FMT_VAR_1, FMT_VAR_2, FMT_VAR_4: begin
                dec_first = {58'd0, i_data_byte[5:0]};
                unique case (i_data_byte[7:6])
                    PFX_1:   dec_len = 4'd1;
                    PFX_2:   dec_len = 4'd2;
                    PFX_4:   dec_len = 4'd4;
                    default: dec_len = 4'd8;
                endcase
            end
            FMT_FIX_1: dec_len = 4'd1;
            FMT_FIX_2: dec_len = 4'd2;
            FMT_FIX_3: dec_len = 4'd3;
            FMT_FIX_4: dec_len = 4'd4;
            FMT_FIX_8: dec_len = 4'd8;
            default:   dec_bad = 1'b1;
        endcase
    end

    // overrun check shared by encode and first decode byte
    assign field_len = (i_command == CMD_ENCODE) ? enc_len : dec_len;
    assign field_end = {1'b0, i_position} + {13'd0, field_len};
    assign overrun   = (field_end > {1'b0, i_buffer_length});

    assign acc_shift  = {r_acc[55:0], i_data_byte};
    assign remain_dec = (r_remain != 4'd0) ? (r_remain - 4'd1) : r_remain;

    // job building and decode state update
    always_comb begin
        n_busy   = r_busy;
        n_remain = r_remain;
        n_acc    = r_acc;
        n_fend   = r_fend;
        o_push   = 1'b0;

        err_entry.is_enc = 1'b0;
        err_entry.prefix = PFX_1;
        err_entry.len    = 4'd1;
        err_entry.data   = 64'd0;
        err_entry.npos   = POS_ERROR;
        err_entry.status = ST_OK;

        o_entry = err_entry;

        if (i_accept) begin
            if (i_command == CMD_ENCODE) begin
                o_push = 1'b1;
                if (enc_bad) begin
                    o_entry.status = ST_BADFMT;
                end else if (enc_ovf) begin
                    o_entry.status = ST_OVERFLOW;
                end else if (overrun) begin
                    o_entry.status = ST_OVERRUN;
                end else begin
                    o_entry.is_enc = 1'b1;
                    o_entry.prefix = (i_format <= FMT_VAR_4) ? enc_pfx : PFX_1;
                    o_entry.len    = enc_len;
                    o_entry.data   = i_value;
                    o_entry.npos   = field_end[15:0];
                end
            end else if (r_busy) begin
                // continuation byte of a field in progress
                n_acc    = acc_shift;
                n_remain = remain_dec;
                if (remain_dec == 4'd0) begin
                    n_busy        = 1'b0;
                    o_push        = 1'b1;
                    o_entry.data  = acc_shift;
                    o_entry.npos  = r_fend;
                end
            end else begin
                // first byte of a new field
                if (dec_bad) begin
                    o_push         = 1'b1;
                    o_entry.status = ST_BADFMT;
                end else if (overrun) begin
                    o_push         = 1'b1;
                    o_entry.status = ST_OVERRUN;
                end else if (dec_len == 4'd1) begin
                    o_push       = 1'b1;
                    o_entry.data = dec_first;
                    o_entry.npos = field_end[15:0];
                end else begin
                    n_busy   = 1'b1;
                    n_remain = dec_len - 4'd1;
                    n_acc    = dec_first;
                    n_fend   = field_end[15:0];
                end
            end
        end
    end

    // decode field state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_remain <= 4'd0;
        end else begin
            r_busy   <= n_busy;
            r_remain <= n_remain;
        end
        r_acc  <= n_acc;
        r_fend <= n_fend;
    end

endmodule
`default_nettype wire

// ----- sv/qfc_queue.sv -----
// short job queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module qfc_queue
    import qfc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  t_qfc_entry       i_entry,
    input  wire logic        i_pop,
    output t_qfc_entry       o_head,
    output t_qfc_qstat       o_stat
);

    localparam int PW = $clog2(QDEPTH);

    t_qfc_entry    r_mem [QDEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [PW:0]   r_count, n_count;

    assign o_head       = r_mem[r_rptr];
    assign o_stat.full  = (r_count == (PW+1)'(QDEPTH));
    assign o_stat.empty = (r_count == '0);

    // pointer and count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

endmodule
`default_nettype wire

// ----- sv/qfc_back.sv -----
// back part: walks each job and drives the registered result stage
`timescale 1ns / 1ps
`default_nettype none
module qfc_back
    import qfc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  t_qfc_entry       i_head,
    input  wire logic        i_head_valid,
    output logic             o_pop,
    input  wire logic        i_ready,
    output logic             o_valid,
    output logic [7:0]       o_out_byte,
    output logic [63:0]      o_decoded_value,
    output logic [15:0]      o_next_position,
    output logic             o_last,
    output t_qfc_status      o_status
);

    logic        r_valid, n_valid;
    logic [2:0]  r_k, n_k;
    logic [7:0]  r_byte, n_byte;
    logic [63:0] r_dval, n_dval;
    logic [15:0] r_npos, n_npos;
    logic        r_last, n_last;
    t_qfc_status r_status, n_status;

    logic        advance;
    logic [3:0]  len_m1;
    logic [2:0]  idx;
    logic        is_last;
    logic [7:0]  sel_byte;

    assign advance  = !r_valid || i_ready;
    assign len_m1   = i_head.len - 4'd1;
    assign idx      = len_m1[2:0] - r_k;
    assign is_last  = ({1'b0, r_k} == len_m1);
    assign sel_byte = i_head.data[{idx, 3'b000} +: 8];
    assign o_pop    = advance && i_head_valid && is_last;

    // next result from the head job
    always_comb begin
        n_valid  = r_valid;
        n_k      = r_k;
        n_byte   = r_byte;
        n_dval   = r_dval;
        n_npos   = r_npos;
        n_last   = r_last;
        n_status = r_status;
        if (advance) begin
            n_valid = i_head_valid;
            if (i_head_valid) begin
                n_k      = is_last ? 3'd0 : r_k + 3'd1;
                n_npos   = i_head.npos;
                n_last   = is_last;
                n_status = i_head.status;
                if (i_head.is_enc) begin
                    n_byte = (r_k == 3'd0) ? (sel_byte | {i_head.prefix, 6'd0}) : sel_byte;
                    n_dval = 64'd0;
                end else begin
                    n_byte = 8'd0;
                    n_dval = i_head.data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= 3'd0;
        end else begin
            r_valid <= n_valid;
            r_k     <= n_k;
        end
        r_byte   <= n_byte;
        r_dval   <= n_dval;
        r_npos   <= n_npos;
        r_last   <= n_last;
        r_status <= n_status;
    end

    assign o_valid         = r_valid;
    assign o_out_byte      = r_byte;
    assign o_decoded_value = r_dval;
    assign o_next_position = r_npos;
    assign o_last          = r_last;
    assign o_status        = r_status;

endmodule
`default_nettype wire

// ----- sv/quic_field_codec_unit.sv -----
// top level of the packet field codec: varint and fixed field encode and decode
//
//  channel   direction  tdata                                        tuser     tlast
//  slave     in         format, value, data_byte, position, buf_len  command   -
//  master    out        out_byte, decoded_value, next_position       status    last
//
// an encode item gives one result per emitted byte (1 to 8 bytes on the master side);
// decode bytes are taken every cycle the queue has room; each field gives one result
// the back part emits one result per cycle unless stalled: the sustained output rate;
// the slave side takes an item every cycle while the two-entry job queue has room
// reset is synchronous, active low, and empties the queue and the output register
// either side may stall on its own: the queue and the output register part them
`timescale 1ns / 1ps
`default_nettype none
module quic_field_codec_unit
    import qfc_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // format[3:0], value[67:4], data_byte[75:68], position[91:76],
    // buffer_length[107:92], zero fill[111:108]
    input  wire logic [111:0] i_s_tdata,
    // command[0]
    input  wire logic [0:0]   i_s_tuser,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // out_byte[7:0], decoded_value[71:8], next_position[87:72]
    output logic [87:0]       o_m_tdata,
    // status[1:0]
    output logic [1:0]        o_m_tuser,
    output logic              o_m_tlast
);

    logic        accept;
    logic        push;
    logic        pop;
    t_qfc_entry  new_entry;
    t_qfc_entry  head;
    t_qfc_qstat  qstat;
    t_qfc_status status;
    logic [7:0]  out_byte;
    logic [63:0] dval;
    logic [15:0] npos;

    assign o_s_tready = !qstat.full;
    assign accept     = i_s_tvalid && o_s_tready;

    // classify and track decode fields
    qfc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_command       (i_s_tuser[0]),
        .i_format        (i_s_tdata[3:0]),
        .i_value         (i_s_tdata[67:4]),
        .i_data_byte     (i_s_tdata[75:68]),
        .i_position      (i_s_tdata[91:76]),
        .i_buffer_length (i_s_tdata[107:92]),
        .o_entry         (new_entry),
        .o_push          (push)
    );

    // job queue
    qfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (new_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    // result generation
    qfc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_head_valid    (!qstat.empty),
        .o_pop           (pop),
        .i_ready         (i_m_tready),
        .o_valid         (o_m_tvalid),
        .o_out_byte      (out_byte),
        .o_decoded_value (dval),
        .o_next_position (npos),
        .o_last          (o_m_tlast),
        .o_status        (status)
    );

    assign o_m_tdata = {npos, dval, out_byte};
    assign o_m_tuser = status;

`ifndef SYNTHESIS
    // an error result is a single final result with the error position
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != ST_OK) |-> (o_m_tlast && o_m_tdata[87:72] == POS_ERROR))
        else $error("error result without last or error position");

    // queue can never be both full and empty
    a_q_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(qstat.full && qstat.empty))
        else $error("job queue status inconsistent");

    // after reset the output stage and the queue start empty
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && qstat.empty))
        else $error("state left over after reset");

    // a decode result never carries an encoded byte
    a_dec_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[71:8] != 64'd0) |-> (o_m_tdata[7:0] == 8'd0 && o_m_tlast))
        else $error("decoded value mixed with encoded byte");
`endif

endmodule
`default_nettype wire
